FILE: hdl/dmxr_pkg.sv
package dmxr_pkg;

    localparam int DMX_SLOTS_DEF     = 512;
    localparam int RING_DEPTH_DEF    = 16;
    localparam int RDM_BUF_BYTES_DEF = 512;
    localparam int UID_BYTES         = 6;
    localparam int EUID_BYTES        = 2 * UID_BYTES;
    localparam int DISC_CS_BYTES     = 4;
    localparam int QUEUE_DEPTH       = 4;

    // write position holds up to RDM_BUF_BYTES (1024 at most)
    localparam int WPOS_W = 11;

    localparam logic [7:0] SC_DMX      = 8'h00;
    localparam logic [7:0] SC_RDM      = 8'hCC;
    localparam logic [7:0] SUB_SC_RDM  = 8'h01;
    localparam logic [7:0] DISC_PRE    = 8'hFE;
    localparam logic [7:0] DISC_SEP    = 8'hAA;

    localparam logic [1:0] REQ_BREAK   = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMER   = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DMX_SLOT = 3'd1;
    localparam logic [2:0] EV_RDM_BYTE = 3'd2;
    localparam logic [2:0] EV_DMX_DONE = 3'd3;
    localparam logic [2:0] EV_COMMIT   = 3'd4;
    localparam logic [2:0] EV_DROP     = 3'd5;
    localparam logic [2:0] EV_HANDOUT  = 3'd6;
    localparam logic [2:0] EV_EMPTY    = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } dmxr_req_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [9:0]  byte_position;
        logic [7:0]  byte_out;
        logic [3:0]  ring_slot;
        logic [9:0]  slots_in_frame;
        logic [31:0] break_interval_us;
        logic [31:0] slot_interval_us;
        logic [31:0] dmx_frame_count;
        logic [31:0] rdm_frame_count;
        logic [31:0] commit_time_us;
    } dmxr_res_t;

    typedef struct packed {
        logic is_dmx_sc;
        logic is_rdm_sc;
        logic is_disc_pre;
        logic is_disc_sep;
    } dmxr_flags_t;

    typedef struct packed {
        logic [1:0]  kind;
        dmxr_flags_t flags;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } dmxr_item_t;

endpackage

FILE: hdl/dmxr_front.sv
module dmxr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dmxr_pkg::dmxr_req_t  req,
    output logic               q_push,
    output dmxr_pkg::dmxr_item_t q_item,
    input  logic               q_full
);
    import dmxr_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    dmxr_item_t item_reg;
    dmxr_item_t item_next;
    logic       accept;

    assign q_push    = front_valid_reg && !q_full;
    assign req_stall = front_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign q_item    = item_reg;

    always_comb
    begin
        item_next.rx_byte            = req.rx_byte;
        item_next.time_us            = req.time_us;
        item_next.flags.is_dmx_sc    = (req.rx_byte == SC_DMX);
        item_next.flags.is_rdm_sc    = (req.rx_byte == SC_RDM);
        item_next.flags.is_disc_pre  = (req.rx_byte == DISC_PRE);
        item_next.flags.is_disc_sep  = (req.rx_byte == DISC_SEP);
        unique case (req.req_type)
            REQ_BREAK:   item_next.kind = REQ_BREAK;
            REQ_BYTE:    item_next.kind = REQ_BYTE;
            REQ_TIMER:   item_next.kind = REQ_TIMER;
            default:     item_next.kind = REQ_RELEASE;
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/dmxr_queue.sv
module dmxr_queue #(
    parameter int DEPTH = dmxr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dmxr_pkg::dmxr_item_t wdata,
    output logic               full,
    input  logic               pop,
    output dmxr_pkg::dmxr_item_t rdata,
    output logic               empty
);
    import dmxr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dmxr_item_t     mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count lost a push");
`endif

endmodule

FILE: hdl/dmxr_back.sv
module dmxr_back #(
    parameter int DMX_SLOTS     = dmxr_pkg::DMX_SLOTS_DEF,
    parameter int RING_DEPTH    = dmxr_pkg::RING_DEPTH_DEF,
    parameter int RDM_BUF_BYTES = dmxr_pkg::RDM_BUF_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               q_empty,
    input  dmxr_pkg::dmxr_item_t q_item,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output dmxr_pkg::dmxr_res_t  res
);
    import dmxr_pkg::*;

    localparam int RW = $clog2(RING_DEPTH);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_BREAK = 4'd1;
    localparam logic [3:0] PH_DMX   = 4'd2;
    localparam logic [3:0] PH_RDM   = 4'd3;
    localparam logic [3:0] PH_CSH   = 4'd4;
    localparam logic [3:0] PH_CSL   = 4'd5;
    localparam logic [3:0] PH_DFE   = 4'd6;
    localparam logic [3:0] PH_DEUID = 4'd7;
    localparam logic [3:0] PH_DCS   = 4'd8;

    logic              disc_en_reg;
    logic [3:0]        phase_reg,      phase_next;
    logic [WPOS_W-1:0] wpos_reg,       wpos_next;
    logic [15:0]       sum_reg,        sum_next;
    logic [7:0]        len_reg,        len_next;
    logic [7:0]        sub_reg,        sub_next;
    logic [3:0]        disc_reg,       disc_next;
    logic [RW-1:0]     head_reg,       head_next;
    logic [RW-1:0]     tail_reg,       tail_next;
    logic [31:0]       last_byte_reg,  last_byte_next;
    logic [31:0]       last_brk_reg,   last_brk_next;
    logic [31:0]       gap_slot_reg,   gap_slot_next;
    logic [31:0]       gap_brk_reg,    gap_brk_next;
    logic [31:0]       dmx_cnt_reg,    dmx_cnt_next;
    logic [31:0]       rdm_cnt_reg,    rdm_cnt_next;
    logic [31:0]       commit_t_reg,   commit_t_next;
    logic [9:0]        fslots_reg,     fslots_next;
    logic              res_valid_reg,  res_valid_next;
    dmxr_res_t         res_reg,        res_next;

    logic [2:0]        code;
    logic [9:0]        pos;
    logic [7:0]        val;
    logic [3:0]        slot;
    logic [WPOS_W-1:0] wpos_inc;
    logic [RW-1:0]     head_inc;
    logic [RW-1:0]     tail_inc;
    logic [RW+3:0]     head_ext;
    logic [RW+3:0]     tail_ext;

    assign q_pop    = !q_empty && (!res_valid_reg || !res_stall);
    assign wpos_inc = wpos_reg + WPOS_W'(1);
    assign head_inc = (head_reg == RW'(RING_DEPTH - 1)) ? '0 : head_reg + RW'(1);
    assign tail_inc = (tail_reg == RW'(RING_DEPTH - 1)) ? '0 : tail_reg + RW'(1);
    assign head_ext = {4'b0000, head_reg};
    assign tail_ext = {4'b0000, tail_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        wpos_next      = wpos_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        sub_next       = sub_reg;
        disc_next      = disc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        last_byte_next = last_byte_reg;
        last_brk_next  = last_brk_reg;
        gap_slot_next  = gap_slot_reg;
        gap_brk_next   = gap_brk_reg;
        dmx_cnt_next   = dmx_cnt_reg;
        rdm_cnt_next   = rdm_cnt_reg;
        commit_t_next  = commit_t_reg;
        fslots_next    = fslots_reg;
        code           = EV_NONE;
        pos            = '0;
        val            = '0;
        slot           = '0;

        if (q_pop)
        begin
            unique case (q_item.kind)
                REQ_BREAK:
                begin
                    phase_next     = PH_BREAK;
                    gap_brk_next   = q_item.time_us - last_brk_reg;
                    last_brk_next  = q_item.time_us;
                    last_byte_next = q_item.time_us;
                end
                REQ_BYTE:
                begin
                    last_byte_next = q_item.time_us;
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (disc_en_reg && q_item.flags.is_disc_pre)
                            begin
                                phase_next = PH_DFE;
                                wpos_next  = WPOS_W'(1);
                                code       = EV_RDM_BYTE;
                                val        = q_item.rx_byte;
                                slot       = head_ext[3:0];
                            end
                        end
                        PH_BREAK:
                        begin
                            if (q_item.flags.is_dmx_sc)
                            begin
                                phase_next   = PH_DMX;
                                wpos_next    = WPOS_W'(1);
                                dmx_cnt_next = dmx_cnt_reg + 32'd1;
                                code         = EV_DMX_SLOT;
                            end
                            else if (q_item.flags.is_rdm_sc)
                            begin
                                phase_next   = PH_RDM;
                                wpos_next    = WPOS_W'(1);
                                sum_next     = {8'h00, SC_RDM};
                                rdm_cnt_next = rdm_cnt_reg + 32'd1;
                                code         = EV_RDM_BYTE;
                                val          = q_item.rx_byte;
                                slot         = head_ext[3:0];
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_DMX:
                        begin
                            pos           = wpos_reg[9:0];
                            val           = q_item.rx_byte;
                            code          = EV_DMX_SLOT;
                            wpos_next     = wpos_inc;
                            gap_slot_next = q_item.time_us - last_byte_reg;
                            if (wpos_inc > WPOS_W'(DMX_SLOTS))
                            begin
                                phase_next  = PH_IDLE;
                                fslots_next = 10'(DMX_SLOTS);
                                code        = EV_DMX_DONE;
                            end
                        end
                        PH_RDM, PH_CSH, PH_CSL, PH_DFE, PH_DEUID, PH_DCS:
                        begin
                            slot = head_ext[3:0];
                            if (phase_reg == PH_DFE && !q_item.flags.is_disc_pre
                                && !q_item.flags.is_disc_sep)
                            begin
                                phase_next = PH_IDLE;
                                code       = EV_DROP;
                            end
                            else if (wpos_reg >= WPOS_W'(RDM_BUF_BYTES))
                            begin
                                // buffer full: byte is not stored
                                phase_next = PH_IDLE;
                                code       = EV_DROP;
                            end
                            else
                            begin
                                pos       = wpos_reg[9:0];
                                wpos_next = wpos_inc;
                                code      = EV_RDM_BYTE;
                                val       = q_item.rx_byte;
                                unique case (phase_reg)
                                    PH_RDM:
                                    begin
                                        sum_next = sum_reg + {8'h00, q_item.rx_byte};
                                        if (wpos_reg == WPOS_W'(1))
                                        begin
                                            sub_next = q_item.rx_byte;
                                        end
                                        if (wpos_reg == WPOS_W'(2))
                                        begin
                                            len_next = q_item.rx_byte;
                                        end
                                        if (wpos_inc >= WPOS_W'(3)
                                            && wpos_inc == WPOS_W'(len_next))
                                        begin
                                            phase_next = PH_CSH;
                                        end
                                    end
                                    PH_CSH:
                                    begin
                                        sum_next   = sum_reg - {q_item.rx_byte, 8'h00};
                                        phase_next = PH_CSL;
                                    end
                                    PH_CSL:
                                    begin
                                        sum_next   = sum_reg - {8'h00, q_item.rx_byte};
                                        phase_next = PH_IDLE;
                                        if (sum_next == 16'h0000 && sub_reg == SUB_SC_RDM)
                                        begin
                                            head_next     = head_inc;
                                            commit_t_next = q_item.time_us;
                                            code          = EV_COMMIT;
                                        end
                                        else
                                        begin
                                            code = EV_DROP;
                                        end
                                    end
                                    PH_DFE:
                                    begin
                                        if (q_item.flags.is_disc_sep)
                                        begin
                                            phase_next = PH_DEUID;
                                            disc_next  = '0;
                                        end
                                    end
                                    PH_DEUID:
                                    begin
                                        disc_next = disc_reg + 4'd1;
                                        if (disc_next == 4'(EUID_BYTES))
                                        begin
                                            phase_next = PH_DCS;
                                            disc_next  = '0;
                                        end
                                    end
                                    default:
                                    begin
                                        // discovery checksum bytes, committed unchecked
                                        disc_next = disc_reg + 4'd1;
                                        if (disc_next == 4'(DISC_CS_BYTES))
                                        begin
                                            disc_next     = '0;
                                            phase_next    = PH_IDLE;
                                            head_next     = head_inc;
                                            commit_t_next = q_item.time_us;
                                            code          = EV_COMMIT;
                                        end
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                REQ_TIMER:
                begin
                    if (phase_reg == PH_DMX
                        && (q_item.time_us - last_byte_reg) > gap_slot_reg)
                    begin
                        phase_next  = PH_IDLE;
                        fslots_next = 10'(wpos_reg - WPOS_W'(1));
                        code        = EV_DMX_DONE;
                    end
                end
                default:
                begin
                    if (head_reg == tail_reg)
                    begin
                        code = EV_EMPTY;
                    end
                    else
                    begin
                        code      = EV_HANDOUT;
                        slot      = tail_ext[3:0];
                        tail_next = tail_inc;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.event_code        = code;
        res_next.byte_position     = pos;
        res_next.byte_out          = val;
        res_next.ring_slot         = slot;
        res_next.slots_in_frame    = fslots_next;
        res_next.break_interval_us = gap_brk_next;
        res_next.slot_interval_us  = gap_slot_next;
        res_next.dmx_frame_count   = dmx_cnt_next;
        res_next.rdm_frame_count   = rdm_cnt_next;
        res_next.commit_time_us    = commit_t_next;
        if (q_pop)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_en_reg   <= 1'b0;
            phase_reg     <= PH_IDLE;
            wpos_reg      <= '0;
            sum_reg       <= '0;
            len_reg       <= '0;
            sub_reg       <= '0;
            disc_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            last_byte_reg <= '0;
            last_brk_reg  <= '0;
            gap_slot_reg  <= '0;
            gap_brk_reg   <= '0;
            dmx_cnt_reg   <= '0;
            rdm_cnt_reg   <= '0;
            commit_t_reg  <= '0;
            fslots_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                disc_en_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            wpos_reg      <= wpos_next;
            sum_reg       <= sum_next;
            len_reg       <= len_next;
            sub_reg       <= sub_next;
            disc_reg      <= disc_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            last_byte_reg <= last_byte_next;
            last_brk_reg  <= last_brk_next;
            gap_slot_reg  <= gap_slot_next;
            gap_brk_reg   <= gap_brk_next;
            dmx_cnt_reg   <= dmx_cnt_next;
            rdm_cnt_reg   <= rdm_cnt_next;
            commit_t_reg  <= commit_t_next;
            fslots_reg    <= fslots_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_dmx_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DMX |-> (wpos_reg >= WPOS_W'(1) && wpos_reg <= WPOS_W'(DMX_SLOTS)))
        else $error("dmx write position out of frame");

    a_disc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg < 4'(EUID_BYTES))
        else $error("discovery byte count out of range");
`endif

endmodule

FILE: hdl/dmx512_rdm_receive_framer_core.sv
// DMX512 / RDM receive framer. Each request item (break, received byte, timer check or
// release of the oldest RDM frame) yields exactly one result item carrying a store
// event and the current frame statistics. The front stage classifies the byte and
// feeds a four-entry queue; the back stage runs the framing state machine, updating all
// of its state at once, and registers the result. Sustained rate is one item per clock
// while neither side stalls; an accepted item passes from the front register into the
// queue and from the queue into the result register. Either side may stall
// independently. discovery_enable may be written only while no item is in flight.
module dmx512_rdm_receive_framer_core #(
    parameter int DMX_SLOTS     = dmxr_pkg::DMX_SLOTS_DEF,
    parameter int RING_DEPTH    = dmxr_pkg::RING_DEPTH_DEF,
    parameter int RDM_BUF_BYTES = dmxr_pkg::RDM_BUF_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  dmxr_pkg::dmxr_req_t req,
    output logic              res_valid,
    input  logic              res_stall,
    output dmxr_pkg::dmxr_res_t res
);
    import dmxr_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    dmxr_item_t q_wdata;
    dmxr_item_t q_rdata;

    dmxr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_push    (q_push),
        .q_item    (q_wdata),
        .q_full    (q_full)
    );

    dmxr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    dmxr_back #(
        .DMX_SLOTS     (DMX_SLOTS),
        .RING_DEPTH    (RING_DEPTH),
        .RDM_BUF_BYTES (RDM_BUF_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_item      (q_rdata),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

endmodule
